// File: design/rc4_pkg.sv
// Shared constants and codes for the RC4 stream cipher.
`default_nettype none
package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int TABLE_DEPTH   = 256;
  localparam int MAX_KEY_BYTES = 8;
  localparam int KEY_W         = 64;
  localparam int KEY_LEN_W     = 4;
  localparam int KEY_POS_W     = $clog2(MAX_KEY_BYTES);
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 4;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(4);

  typedef enum logic {
    KIND_REKEY = 1'b0,
    KIND_CRYPT = 1'b1
  } kind_t;

  typedef enum logic {
    REG_KEY_BYTES  = 1'b0,
    REG_KEY_LENGTH = 1'b1
  } reg_sel_t;

endpackage
`default_nettype wire

// File: design/rc4_in_if.sv
// Input item channel: operation kind, data byte and last mark.
`default_nettype none
interface rc4_in_if;
  import rc4_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] data_in;
  logic              last;

  modport source (output valid, output kind, output data_in, output last, input ready);
  modport sink   (input valid, input kind, input data_in, input last, output ready);
endinterface
`default_nettype wire

// File: design/rc4_out_if.sv
// Result item channel: processed byte, key status and last mark.
`default_nettype none
interface rc4_out_if;
  import rc4_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;
  logic              key_ready;
  logic              last_out;

  modport source (output valid, output data_out, output key_ready, output last_out,
                  input ready);
  modport sink   (input valid, input data_out, input key_ready, input last_out,
                  output ready);
endinterface
`default_nettype wire

// File: design/rc4_stream_cipher.sv
// RC4 stream cipher: key schedule and keystream generator over one table RAM.
//
// Usage:
//   in_ch  takes items: kind 0 rekeys from the key registers, kind 1 crypts
//          data_in with the next keystream byte. last is copied to last_out.
//   out_ch gives one item per crypt item, none per rekey item.
//   APB port: key_bytes at 0x0 (64 bits), key_length at 0x8 (1..8 bytes).
// Timing:
//   A crypt item goes through ST_CR_J, ST_CR_W1, ST_CR_W2 and ST_CR_OUT to
//   the output register; the next item is taken once back in ST_IDLE. The
//   permutation RAM has one read and one write port: read S[i], read S[j],
//   write S[i], then write S[j] with the read of S[S[i]+S[j]]. A rekey holds
//   the input for 256 fill writes, then ST_KS_RD, ST_KS_J, ST_KS_W1 and
//   ST_KS_W2 for each of 256 schedule steps, then takes the next item. A
//   crypt before the first rekey passes data through with key_ready low.
// Reset clears the indices and the keyed flag; the table holds no value
// until a rekey. While the output register holds an unaccepted item, a
// finished crypt waits in its last state and no new item is taken.
`default_nettype none
module rc4_stream_cipher (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rc4_in_if.sink                             in_ch,
  rc4_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rc4_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rc4_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [rc4_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready
);
  import rc4_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_W1,
    ST_KS_W2,
    ST_CR_J,
    ST_CR_W1,
    ST_CR_W2,
    ST_CR_OUT,
    ST_PASS
  } state_t;

  state_t                state_r;
  logic [KEY_W-1:0]      key_bytes_r;
  logic [KEY_LEN_W-1:0]  key_length_r;
  logic                  keyed_r;
  logic [BYTE_W-1:0]     i_r;
  logic [BYTE_W-1:0]     j_r;
  logic [BYTE_W-1:0]     k_r;
  logic [KEY_POS_W-1:0]  key_pos_r;
  logic [BYTE_W-1:0]     s_a_r;
  logic [BYTE_W-1:0]     s_b_r;
  logic [BYTE_W-1:0]     t_r;
  logic [BYTE_W-1:0]     data_r;
  logic                  last_r;
  logic                  out_valid_r;
  logic [BYTE_W-1:0]     data_out_r;
  logic                  key_ready_r;
  logic                  last_out_r;

  logic [BYTE_W-1:0]     perm_mem [TABLE_DEPTH];
  logic [BYTE_W-1:0]     mem_rd_r;
  logic                  mem_re;
  logic [BYTE_W-1:0]     mem_ra;
  logic                  mem_we;
  logic [BYTE_W-1:0]     mem_wa;
  logic [BYTE_W-1:0]     mem_wd;

  logic                  in_acc;
  logic                  out_free;
  logic                  cfg_wr;
  logic [KEY_LEN_W-1:0]  key_len_eff;
  logic [KEY_LEN_W-1:0]  pos_inc;
  logic [KEY_POS_W-1:0]  key_pos_nxt;
  logic [BYTE_W-1:0]     key_byte;
  logic [BYTE_W-1:0]     ks_j_nxt;
  logic [BYTE_W-1:0]     cr_j_nxt;
  logic [BYTE_W-1:0]     keystream;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_acc          = in_ch.valid && (state_r == ST_IDLE);
  assign out_free        = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = data_out_r;
  assign out_ch.key_ready = key_ready_r;
  assign out_ch.last_out = last_out_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_KEY_LENGTH) ?
                  CFG_DATA_W'(key_length_r) : CFG_DATA_W'(key_bytes_r);

  always_comb begin
    if (key_length_r == '0) begin
      key_len_eff = KEY_LEN_W'(1);
    end else if (key_length_r > KEY_LEN_W'(MAX_KEY_BYTES)) begin
      key_len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
    end else begin
      key_len_eff = key_length_r;
    end
  end

  assign pos_inc     = KEY_LEN_W'(key_pos_r) + KEY_LEN_W'(1);
  assign key_pos_nxt = (pos_inc >= key_len_eff) ? '0 : pos_inc[KEY_POS_W-1:0];
  assign key_byte    = key_bytes_r[key_pos_r*BYTE_W +: BYTE_W];
  assign ks_j_nxt    = j_r + mem_rd_r + key_byte;
  assign cr_j_nxt    = j_r + mem_rd_r;
  // S[j] is written in the same cycle as the final read; forward it
  assign keystream   = (t_r == j_r) ? s_a_r : mem_rd_r;

  always_comb begin
    mem_re = 1'b0;
    mem_ra = i_r + BYTE_W'(1);
    mem_we = 1'b0;
    mem_wa = k_r;
    mem_wd = k_r;
    case (state_r)
      ST_IDLE: begin
        mem_re = in_acc && (in_ch.kind == KIND_CRYPT) && keyed_r;
      end
      ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_KS_RD: begin
        mem_re = 1'b1;
        mem_ra = k_r;
      end
      ST_KS_J: begin
        mem_re = 1'b1;
        mem_ra = ks_j_nxt;
      end
      ST_KS_W1: begin
        mem_we = 1'b1;
        mem_wd = mem_rd_r;
      end
      ST_KS_W2: begin
        mem_we = 1'b1;
        mem_wa = j_r;
        mem_wd = s_a_r;
      end
      ST_CR_J: begin
        mem_re = 1'b1;
        mem_ra = cr_j_nxt;
      end
      ST_CR_W1: begin
        mem_we = 1'b1;
        mem_wa = i_r;
        mem_wd = mem_rd_r;
      end
      ST_CR_W2: begin
        mem_we = 1'b1;
        mem_wa = j_r;
        mem_wd = s_a_r;
        mem_re = 1'b1;
        mem_ra = s_a_r + s_b_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      perm_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= perm_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      key_bytes_r  <= '0;
      key_length_r <= KEY_LEN_RESET;
      keyed_r      <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      key_pos_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !(state_r inside {ST_CR_OUT, ST_PASS})) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[CFG_ADDR_W-1] == REG_KEY_LENGTH) begin
          key_length_r <= pwdata[KEY_LEN_W-1:0];
        end else begin
          key_bytes_r <= pwdata[KEY_W-1:0];
        end
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            data_r <= in_ch.data_in;
            last_r <= in_ch.last;
            if (in_ch.kind == KIND_REKEY) begin
              k_r     <= '0;
              state_r <= ST_FILL;
            end else if (keyed_r) begin
              i_r     <= i_r + BYTE_W'(1);
              state_r <= ST_CR_J;
            end else begin
              state_r <= ST_PASS;
            end
          end
        end
        ST_FILL: begin
          k_r <= k_r + BYTE_W'(1);
          if (k_r == BYTE_W'(TABLE_DEPTH - 1)) begin
            j_r       <= '0;
            key_pos_r <= '0;
            state_r   <= ST_KS_RD;
          end
        end
        ST_KS_RD: begin
          state_r <= ST_KS_J;
        end
        ST_KS_J: begin
          s_a_r   <= mem_rd_r;
          j_r     <= ks_j_nxt;
          state_r <= ST_KS_W1;
        end
        ST_KS_W1: begin
          state_r <= ST_KS_W2;
        end
        ST_KS_W2: begin
          k_r       <= k_r + BYTE_W'(1);
          key_pos_r <= key_pos_nxt;
          if (k_r == BYTE_W'(TABLE_DEPTH - 1)) begin
            keyed_r <= 1'b1;
            i_r     <= '0;
            j_r     <= '0;
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_KS_RD;
          end
        end
        ST_CR_J: begin
          s_a_r   <= mem_rd_r;
          j_r     <= cr_j_nxt;
          state_r <= ST_CR_W1;
        end
        ST_CR_W1: begin
          s_b_r   <= mem_rd_r;
          state_r <= ST_CR_W2;
        end
        ST_CR_W2: begin
          t_r     <= s_a_r + s_b_r;
          state_r <= ST_CR_OUT;
        end
        ST_CR_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            data_out_r  <= data_r ^ keystream;
            key_ready_r <= 1'b1;
            last_out_r  <= last_r;
            state_r     <= ST_IDLE;
          end else begin
            out_valid_r <= out_valid_r;
          end
        end
        ST_PASS: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            data_out_r  <= data_r;
            key_ready_r <= 1'b0;
            last_out_r  <= last_r;
            state_r     <= ST_IDLE;
          end else begin
            out_valid_r <= out_valid_r;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
